@@ hdl/b64se_pkg.sv @@
// shared types, constants and alphabet mapping for the base64 stream encoder
package b64se_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] char_first;
      logic [7:0] char_second;
      logic [7:0] char_third;
      logic [7:0] char_fourth;
      logic       group_last;
   } rsp_type;

   typedef enum logic [1:0] {
      GROUP_EMPTY = 2'd0,
      GROUP_ONE   = 2'd1,
      GROUP_TWO   = 2'd2,
      GROUP_SPARE = 2'd3
   } group_pos_type;

   typedef enum logic [1:0] {
      COUNT_NONE  = 2'd0,
      COUNT_ONE   = 2'd1,
      COUNT_TWO   = 2'd2,
      COUNT_THREE = 2'd3
   } group_count_type;

   typedef struct packed {
      logic [7:0]      byte_one;
      logic [7:0]      byte_two;
      logic [7:0]      byte_three;
      group_count_type count;
      logic            last;
   } group_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   function automatic logic [7:0] b64_sym(input logic [5:0] idx);
      logic [7:0] wide;
      logic [7:0] sym;
      wide = {2'b00, idx};
      if (idx < 6'd26) begin
         sym = wide + 8'd65;
      end else if (idx < 6'd52) begin
         sym = wide + 8'd71;
      end else if (idx < 6'd62) begin
         sym = wide - 8'd4;
      end else if (idx == 6'd62) begin
         sym = 8'h2B;
      end else begin
         sym = 8'h2F;
      end
      return sym;
   endfunction

endpackage

@@ hdl/b64se_front.sv @@
// front end: accepts bytes and gathers them into groups of up to three
module b64se_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  b64se_pkg::req_type          req_item,
   input  b64se_pkg::queue_status_type q_status,
   output logic                        push,
   output b64se_pkg::group_type        push_group
);
   import b64se_pkg::*;

   group_pos_type pos_ff, pos_in;
   logic [7:0]    held_first_ff, held_first_in;
   logic [7:0]    held_second_ff, held_second_in;
   logic          accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      pos_in         = pos_ff;
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      push           = 1'b0;
      push_group     = '{byte_one: req_item.data_byte, byte_two: 8'd0, byte_three: 8'd0,
                         count: COUNT_ONE, last: 1'b1};
      if (accept) begin
         unique case (pos_ff)
            GROUP_ONE: begin
               if (req_item.final_byte) begin
                  push       = 1'b1;
                  push_group = '{byte_one: held_first_ff, byte_two: req_item.data_byte,
                                 byte_three: 8'd0, count: COUNT_TWO, last: 1'b1};
                  pos_in     = GROUP_EMPTY;
               end else begin
                  held_second_in = req_item.data_byte;
                  pos_in         = GROUP_TWO;
               end
            end
            GROUP_TWO: begin
               push       = 1'b1;
               push_group = '{byte_one: held_first_ff, byte_two: held_second_ff,
                              byte_three: req_item.data_byte, count: COUNT_THREE,
                              last: req_item.final_byte};
               pos_in     = GROUP_EMPTY;
            end
            GROUP_EMPTY, GROUP_SPARE: begin
               if (req_item.final_byte) begin
                  push   = 1'b1;
                  pos_in = GROUP_EMPTY;
               end else begin
                  held_first_in = req_item.data_byte;
                  pos_in        = GROUP_ONE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= GROUP_EMPTY;
      end else begin
         pos_ff <= pos_in;
      end
      held_first_ff  <= held_first_in;
      held_second_ff <= held_second_in;
   end

endmodule

@@ hdl/b64se_queue.sv @@
// short group queue between front and back ends
module b64se_queue #(
   parameter int QUEUE_DEPTH = b64se_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  b64se_pkg::group_type        push_group,
   input  logic                        pop,
   output b64se_pkg::group_type        pop_group,
   output b64se_pkg::queue_status_type q_status
);
   import b64se_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   group_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_status.full  = (count_ff == FULL_CNT);
   assign q_status.valid = (count_ff != '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && q_status.valid;
   assign pop_group      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

@@ hdl/b64se_back.sv @@
// back end: maps a group to four characters and holds the result register
module b64se_back (
   input  logic                        clock,
   input  logic                        reset,
   input  b64se_pkg::queue_status_type q_status,
   input  b64se_pkg::group_type        pop_group,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output b64se_pkg::rsp_type          rsp_item
);
   import b64se_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   assign pop       = q_status.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (pop) begin
         rsp_valid_in       = 1'b1;
         rsp_in.char_first  = b64_sym(pop_group.byte_one[7:2]);
         rsp_in.char_second = b64_sym({pop_group.byte_one[1:0], pop_group.byte_two[7:4]});
         rsp_in.char_third  = (pop_group.count == COUNT_ONE) ? PAD_CHAR
                            : b64_sym({pop_group.byte_two[3:0], pop_group.byte_three[7:6]});
         rsp_in.char_fourth = (pop_group.count != COUNT_THREE) ? PAD_CHAR
                            : b64_sym(pop_group.byte_three[5:0]);
         rsp_in.group_last  = pop_group.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

@@ hdl/base64_stream_encoder_top.sv @@
// base64 stream encoder top level: front end, group queue and back end
// Takes one byte per cycle (an item with a final flag) and returns one item of
// four base64 characters for every third byte and for the final byte of a
// message, padded with '=' for a short final group and flagged as the last
// group. The front end gathers bytes and queues completed groups, the back end
// maps them to characters into a registered output; once its closing byte is
// taken, a group is written to the group queue and then to the result register,
// and bytes are taken every cycle while the queue (QUEUE_DEPTH entries) has room.
module base64_stream_encoder_top #(
   parameter int QUEUE_DEPTH = b64se_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  b64se_pkg::req_type req_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output b64se_pkg::rsp_type rsp_item
);
   import b64se_pkg::*;

   queue_status_type q_status;
   group_type        push_group;
   group_type        pop_group;
   logic             push;
   logic             pop;

   b64se_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .q_status   (q_status),
      .push       (push),
      .push_group (push_group)
   );

   b64se_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .pop_group  (pop_group),
      .q_status   (q_status)
   );

   b64se_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_group (pop_group),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
